// ----- src/linear_interp_resampler_macros.svh -----
// Assertion macros for the linear interpolation resampler RTL.
`ifndef LINEAR_INTERP_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_MACROS_SVH

// Checks a consequence in the same cycle as its antecedent.
`define LIR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define LIR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lir_pkg.sv -----
// Package with the constants, types and state encoding of the resampler.
`timescale 1ns / 1ps

package lir_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int RATE_W       = 18;
    localparam int PHASE_W      = 19;
    localparam int MAX_UPSAMPLE = 16;
    localparam int MAX_RESULTS  = 32;
    localparam int CNT_W        = $clog2(MAX_RESULTS);
    localparam int UPS_W        = RATE_W + $clog2(MAX_UPSAMPLE) + 1;

    localparam logic [RATE_W-1:0] RESET_RATE = RATE_W'(22050);

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_SOURCE_RATE = 1'b0;
    localparam logic REG_TARGET_RATE = 1'b1;

    localparam int MUL_X_W    = SAMPLE_W + 1;
    localparam int MUL_Y_W    = PHASE_W + 1;
    localparam int ACC_W      = MUL_X_W + MUL_Y_W;
    localparam int DIVIDEND_W = ACC_W;
    localparam int DIVISOR_W  = RATE_W + 1;
    localparam int QUO_W      = SAMPLE_W;
    localparam int QCNT_W     = $clog2(QUO_W);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENTRY,
        ST_PASS,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_STEP,
        ST_EMIT
    } lir_state_t;

    typedef struct packed {
        logic [RATE_W-1:0] source_rate;
        logic [RATE_W-1:0] target_rate;
    } lir_rates_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } lir_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } lir_div_rsp_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       run_last;
        logic                       buffer_end;
    } lir_result_t;

endpackage

// ----- src/lir_regs.sv -----
// APB register file holding the source and target sample rates.
`timescale 1ns / 1ps

module lir_regs import lir_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output lir_rates_t            rates
);

    logic [RATE_W-1:0] source_rate_reg;
    logic [RATE_W-1:0] target_rate_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_rate_reg <= RESET_RATE;
            target_rate_reg <= RESET_RATE;
        end else if (wr_en) begin
            case (paddr[2])
                REG_SOURCE_RATE: source_rate_reg <= pwdata[RATE_W-1:0];
                REG_TARGET_RATE: target_rate_reg <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SOURCE_RATE: prdata = APB_DATA_W'(source_rate_reg);
            REG_TARGET_RATE: prdata = APB_DATA_W'(target_rate_reg);
            default:         prdata = '0;
        endcase
    end

    assign rates.source_rate = source_rate_reg;
    assign rates.target_rate = target_rate_reg;

endmodule

// ----- src/lir_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module lir_div import lir_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  lir_div_req_t req,
    output lir_div_rsp_t rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [QCNT_W-1:0]     cnt_reg;
    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DIVIDEND_W-1:0] dsh_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [DIVIDEND_W:0]   trial;
    logic                  fits;

    assign trial = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign fits  = !trial[DIVIDEND_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == QCNT_W'(QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The divisor starts aligned with the top quotient bit and walks down.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.dividend;
            dsh_reg <= DIVIDEND_W'(req.divisor) << (QUO_W - 1);
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= trial[DIVIDEND_W-1:0];
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- src/lir_ctrl.sv -----
// Sequencer with the shared multiplier, phase tracking and result generation.
`timescale 1ns / 1ps
`include "linear_interp_resampler_macros.svh"

module lir_ctrl import lir_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lir_rates_t                 rates,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic                       in_last,
    input  logic                       out_free,
    output lir_result_t                result,
    output lir_div_req_t               div_req,
    input  lir_div_rsp_t               div_rsp
);

    lir_state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] b_reg, b_next;
    logic                       last_reg, last_next;
    logic signed [SAMPLE_W-1:0] held_reg, held_next;
    logic                       have_held_reg, have_held_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic                       hold_mode_reg, hold_mode_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] res_sample_reg, res_sample_next;
    logic                       res_run_last_reg, res_run_last_next;
    logic                       res_buf_end_reg, res_buf_end_next;
    logic                       done_reg, done_next;

    logic [RATE_W-1:0]          src;
    logic [RATE_W-1:0]          dst;
    logic [PHASE_W-1:0]         dst_ext;
    logic [UPS_W-1:0]           up_limit;
    logic                       bypass;
    logic [PHASE_W:0]           phase_sum;
    logic [PHASE_W-1:0]         phase_adv;
    logic                       adv_below;
    logic [PHASE_W-1:0]         adv_wrap;
    logic                       wrap_below;
    logic                       cur_below;
    logic [PHASE_W-1:0]         cur_wrap;
    logic                       cur_wrap_below;
    logic                       not_full;
    logic [SAMPLE_W-1:0]        a_off;
    logic signed [MUL_X_W-1:0]  mul_x;
    logic signed [MUL_Y_W-1:0]  mul_y;
    logic signed [ACC_W-1:0]    product;
    logic                       emit;

    assign src      = rates.source_rate;
    assign dst      = rates.target_rate;
    assign dst_ext  = PHASE_W'(dst);
    assign up_limit = UPS_W'(src) * UPS_W'(MAX_UPSAMPLE);
    assign bypass   = (src == dst) || (dst == '0) || (UPS_W'(dst) > up_limit);

    assign phase_sum      = {1'b0, phase_reg} + (PHASE_W + 1)'(src);
    assign phase_adv      = phase_sum[PHASE_W-1:0];
    assign adv_below      = phase_adv < dst_ext;
    assign adv_wrap       = adv_below ? '0 : (phase_adv - dst_ext);
    assign wrap_below     = adv_wrap < dst_ext;
    assign cur_below      = phase_reg < dst_ext;
    assign cur_wrap       = phase_reg - dst_ext;
    assign cur_wrap_below = cur_wrap < dst_ext;
    assign not_full       = n_reg != CNT_W'(MAX_RESULTS - 1);

    // The sum a*(dst-ph) + b*ph is formed as (a+32768)*dst + (b-a)*ph, which keeps
    // it non-negative so the divider can work unsigned; the offset is undone by
    // flipping the quotient's top bit.
    assign a_off = {~held_reg[SAMPLE_W-1], held_reg[SAMPLE_W-2:0]};

    always_comb begin
        if (state_reg == ST_MUL_B) begin
            mul_x = {b_reg[SAMPLE_W-1], b_reg} - {held_reg[SAMPLE_W-1], held_reg};
            mul_y = $signed({1'b0, phase_reg});
        end else begin
            mul_x = $signed({1'b0, a_off});
            mul_y = $signed({{(MUL_Y_W - RATE_W){1'b0}}, dst});
        end
    end

    assign product = mul_x * mul_y;

    assign div_req.start    = (state_reg == ST_DIV_GO);
    assign div_req.dividend = DIVIDEND_W'({acc_reg[ACC_W-2:0], 1'b0}) + DIVIDEND_W'(dst);
    assign div_req.divisor  = {dst, 1'b0};

    assign in_ready = (state_reg == ST_IDLE);
    assign emit     = ((state_reg == ST_EMIT) || (state_reg == ST_PASS)) && out_free;

    assign result.valid      = emit;
    assign result.sample     = (state_reg == ST_PASS) ? b_reg : res_sample_reg;
    assign result.run_last   = (state_reg == ST_PASS) ? 1'b1 : res_run_last_reg;
    assign result.buffer_end = (state_reg == ST_PASS) ? last_reg : res_buf_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= '0;
            have_held_reg <= 1'b0;
            phase_reg     <= '0;
            n_reg         <= '0;
            hold_mode_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            held_reg      <= held_next;
            have_held_reg <= have_held_next;
            phase_reg     <= phase_next;
            n_reg         <= n_next;
            hold_mode_reg <= hold_mode_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_reg            <= b_next;
        last_reg         <= last_next;
        acc_reg          <= acc_next;
        res_sample_reg   <= res_sample_next;
        res_run_last_reg <= res_run_last_next;
        res_buf_end_reg  <= res_buf_end_next;
    end

    always_comb begin
        state_next        = state_reg;
        b_next            = b_reg;
        last_next         = last_reg;
        held_next         = held_reg;
        have_held_next    = have_held_reg;
        phase_next        = phase_reg;
        n_next            = n_reg;
        hold_mode_next    = hold_mode_reg;
        acc_next          = acc_reg;
        res_sample_next   = res_sample_reg;
        res_run_last_next = res_run_last_reg;
        res_buf_end_next  = res_buf_end_reg;
        done_next         = done_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    b_next     = in_sample;
                    last_next  = in_last;
                    n_next     = '0;
                    state_next = ST_ENTRY;
                end
            end

            ST_ENTRY: begin
                if (bypass) begin
                    state_next = ST_PASS;
                end else if (have_held_reg && cur_below) begin
                    hold_mode_next = 1'b0;
                    state_next     = ST_MUL_A;
                end else begin
                    // No output falls between the held sample and this one.
                    held_next      = b_reg;
                    have_held_next = 1'b1;
                    if (have_held_reg) begin
                        phase_next = cur_wrap;
                    end
                    state_next = ST_IDLE;
                    if (last_reg) begin
                        if (have_held_reg ? cur_wrap_below : cur_below) begin
                            hold_mode_next = 1'b1;
                            state_next     = ST_STEP;
                        end else begin
                            held_next      = '0;
                            have_held_next = 1'b0;
                            phase_next     = '0;
                        end
                    end
                end
            end

            ST_PASS: begin
                if (out_free) begin
                    if (last_reg) begin
                        held_next      = '0;
                        have_held_next = 1'b0;
                        phase_next     = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_MUL_A: begin
                acc_next   = product;
                state_next = ST_MUL_B;
            end

            ST_MUL_B: begin
                acc_next   = acc_reg + product;
                state_next = ST_DIV_GO;
            end

            ST_DIV_GO: begin
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    res_sample_next = $signed({~div_rsp.quotient[QUO_W-1],
                                               div_rsp.quotient[QUO_W-2:0]});
                    state_next      = ST_STEP;
                end
            end

            ST_STEP: begin
                // Look one position ahead so the flags of this result are known now.
                res_run_last_next = 1'b0;
                res_buf_end_next  = 1'b0;
                done_next         = 1'b0;
                if (hold_mode_reg) begin
                    res_sample_next = b_reg;
                end
                if (adv_below && not_full) begin
                    phase_next = phase_adv;
                end else if (!hold_mode_reg) begin
                    held_next      = b_reg;
                    have_held_next = 1'b1;
                    if (last_reg && wrap_below && not_full) begin
                        phase_next     = adv_wrap;
                        hold_mode_next = 1'b1;
                    end else begin
                        res_run_last_next = 1'b1;
                        res_buf_end_next  = last_reg;
                        done_next         = 1'b1;
                        phase_next        = adv_wrap;
                        if (last_reg) begin
                            held_next      = '0;
                            have_held_next = 1'b0;
                            phase_next     = '0;
                        end
                    end
                end else begin
                    res_run_last_next = 1'b1;
                    res_buf_end_next  = 1'b1;
                    done_next         = 1'b1;
                    held_next         = '0;
                    have_held_next    = 1'b0;
                    phase_next        = '0;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT: begin
                if (out_free) begin
                    n_next = n_reg + 1'b1;
                    if (done_reg) begin
                        state_next = ST_IDLE;
                    end else if (hold_mode_reg) begin
                        state_next = ST_STEP;
                    end else begin
                        state_next = ST_MUL_A;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `LIR_ASSERT_SAME(a_emit_free, aclk, aresetn, result.valid, out_free, "result sent while output register busy")
    `LIR_ASSERT_SAME(a_phase_in_range, aclk, aresetn, state_reg == ST_MUL_B, phase_reg < dst_ext, "interpolation phase not below target rate")
    `LIR_ASSERT_SAME(a_phase_clear, aclk, aresetn, !have_held_reg, phase_reg == '0, "phase nonzero without a held sample")
    `LIR_ASSERT_SAME(a_count_bound, aclk, aresetn, (state_reg == ST_EMIT) && (n_reg == CNT_W'(MAX_RESULTS - 1)), done_reg, "result count limit exceeded")
    `LIR_ASSERT_SAME(a_div_idle, aclk, aresetn, div_req.start, !div_rsp.busy, "divider started while busy")
    `LIR_ASSERT_NEXT(a_item_release, aclk, aresetn, (state_reg == ST_EMIT) && out_free && done_reg, in_ready, "not ready after final result of an item")

endmodule

// ----- src/linear_interp_resampler.sv -----
// Top level of the linear interpolation sample rate converter with its output register.
// An interpolated result passes two multiply passes, a divider start, the 16 quotient bits and
// the done flag of the divider, then a step and an emit state. A result that repeats the final
// sample takes only the step and emit states; a bypassed item takes the entry and pass states.
// A new item is taken only in the idle state, once every result of the last one has been sent.
// Reset is synchronous, active low: rates return to 22050; held sample, phase, handshakes clear.
`timescale 1ns / 1ps

module linear_interp_resampler import lir_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic                       s_buffer_last,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_out,
    output logic                       m_run_last,
    output logic                       m_buffer_end,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    lir_rates_t   rates;
    lir_div_req_t div_req;
    lir_div_rsp_t div_rsp;
    lir_result_t  result;
    logic         out_free;

    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic                       m_run_last_reg;
    logic                       m_buffer_end_reg;

    assign out_free = !m_valid_reg || m_ready;

    lir_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rates   (rates)
    );

    lir_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    lir_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rates     (rates),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_sample (s_sample_in),
        .in_last   (s_buffer_last),
        .out_free  (out_free),
        .result    (result),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            m_sample_reg     <= result.sample;
            m_run_last_reg   <= result.run_last;
            m_buffer_end_reg <= result.buffer_end;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_buffer_end = m_buffer_end_reg;

endmodule
